### src/dati_pkg.sv
// shared types and constants for the decimal ascii to integer parser
package dati_pkg;

  typedef enum logic [1:0] {
    ModeU64 = 2'd0,
    ModeU32 = 2'd1,
    ModeS64 = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    KindDigit = 3'b001,
    KindSign  = 3'b010,
    KindBad   = 3'b100
  } kind_e;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharPlus  = 8'h2b;

  localparam int unsigned MaxDigitsDefault = 20;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // one classified character on its way to the accumulator
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  digit;
    logic        minus;
    logic        last;
    mode_e       mode;
  } cls_item_t;

endpackage

### src/decimal_ascii_to_integer.sv
// top level of the decimal ascii to integer parser
// a final character is first written into the queue, then its result into the output register
// throughput: one character per cycle while the queue is not full, set by the combinational times-ten add
// a two-entry queue lets input be taken while a result waits on the output register
// reset: asynchronous active low; mode returns to unsigned 64-bit, string state clears
module decimal_ascii_to_integer #(
  parameter int unsigned MAX_DIGITS = dati_pkg::MaxDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic [7:0]  char_byte_i,
  input  logic        last_byte_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [63:0] parsed_value_o,
  output logic        parse_error_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);
  import dati_pkg::*;

  mode_e     mode_q, mode_d;
  cls_item_t front_item;
  cls_item_t back_item;
  logic      push;
  logic      pop;
  logic      full;
  logic      q_valid;

  assign mode_d = cfg_we_i ? mode_e'(cfg_wdata_i) : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeU64;
    end else begin
      mode_q <= mode_d;
    end
  end

  dati_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_byte_i (char_byte_i),
    .last_byte_i (last_byte_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_q),
    .full_i      (full),
    .push_o      (push),
    .item_o      (front_item)
  );

  dati_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (back_item)
  );

  dati_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (back_item),
    .pop_o          (pop),
    .parsed_value_o (parsed_value_o),
    .parse_error_o  (parse_error_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

endmodule

### src/dati_front.sv
// front end: accepts characters, classifies them and pushes them into the queue
module dati_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        char_byte_i,
  input  logic              last_byte_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dati_pkg::mode_e   mode_i,
  input  logic              full_i,
  output logic              push_o,
  output dati_pkg::cls_item_t item_o
);
  import dati_pkg::*;

  logic at_start_q, at_start_d;
  kind_e kind;

  always_comb begin
    if (char_byte_i inside {[CharZero:CharNine]}) begin
      kind = KindDigit;
    end else if (at_start_q && (mode_i == ModeS64) &&
                 ((char_byte_i == CharPlus) || (char_byte_i == CharMinus))) begin
      kind = KindSign;
    end else begin
      kind = KindBad;
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // ascii digits keep their value in the low nibble
  assign item_o.kind  = kind;
  assign item_o.digit = char_byte_i[3:0];
  assign item_o.minus = (char_byte_i == CharMinus);
  assign item_o.last  = last_byte_i;
  assign item_o.mode  = mode_i;

  always_comb begin
    at_start_d = at_start_q;
    if (push_o) begin
      at_start_d = last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
    end else begin
      at_start_q <= at_start_d;
    end
  end

endmodule

### src/dati_fifo.sv
// short queue between the classifying front end and the accumulating back end
module dati_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dati_pkg::cls_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output dati_pkg::cls_item_t item_o
);
  import dati_pkg::*;

  localparam logic [FifoPtrW-1:0] LastPtr = FifoPtrW'(FifoDepth - 1);
  localparam logic [FifoCntW-1:0] FullCnt = FifoCntW'(FifoDepth);

  cls_item_t            mem_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTH
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue fill count beyond depth");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("queue popped while empty");
`endif

endmodule

### src/dati_back.sv
// back end: times-ten accumulation, range check and the registered result
module dati_back #(
  parameter int unsigned MAX_DIGITS = dati_pkg::MaxDigitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  dati_pkg::cls_item_t item_i,
  output logic                pop_o,
  output logic [63:0]         parsed_value_o,
  output logic                parse_error_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);
  import dati_pkg::*;

  localparam int unsigned     CntW   = $clog2(MAX_DIGITS + 2);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DIGITS);

  logic [63:0]     acc_q, acc_d, acc_n;
  logic            ovf_q, ovf_d, ovf_n;
  logic            bad_q, bad_d, bad_n;
  logic            neg_q, neg_d, neg_n;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_n;
  logic            out_valid_q, out_valid_d;
  logic [63:0]     value_q, value_d;
  logic            error_q, error_d;
  logic [67:0]     sum;
  logic            err;
  logic            range_err;
  logic            load;

  // acc * 10 + digit as two shifted copies plus the digit
  assign sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, item_i.digit};

  // a non-final item never needs the output register
  assign pop_o = valid_i && (!item_i.last || !out_valid_q || out_ready_i);
  assign load  = pop_o && item_i.last;

  always_comb begin
    acc_n = acc_q;
    ovf_n = ovf_q;
    bad_n = bad_q;
    neg_n = neg_q;
    cnt_n = cnt_q;
    case (item_i.kind)
      KindDigit: begin
        if (cnt_q <= MaxCnt) begin
          cnt_n = cnt_q + 1'b1;
        end
        if (!ovf_q) begin
          if (sum[67:64] != 4'd0) begin
            ovf_n = 1'b1;
          end else begin
            acc_n = sum[63:0];
          end
        end
      end
      KindSign: begin
        neg_n = item_i.minus;
      end
      default: begin
        bad_n = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (item_i.mode)
      ModeU32: range_err = (acc_n[63:32] != 32'd0);
      ModeS64: range_err = neg_n ? (acc_n[63] && (acc_n[62:0] != 63'd0)) : acc_n[63];
      default: range_err = 1'b0;
    endcase
  end

  always_comb begin
    err = ovf_n || bad_n || (cnt_n == '0) || (cnt_n > MaxCnt) || range_err;
    value_d = value_q;
    error_d = error_q;
    if (load) begin
      error_d = err;
      if (err) begin
        value_d = '0;
      end else if ((item_i.mode == ModeS64) && neg_n) begin
        value_d = '0 - acc_n;
      end else begin
        value_d = acc_n;
      end
    end
  end

  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    bad_d = bad_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    if (pop_o) begin
      if (item_i.last) begin
        acc_d = '0;
        ovf_d = 1'b0;
        bad_d = 1'b0;
        neg_d = 1'b0;
        cnt_d = '0;
      end else begin
        acc_d = acc_n;
        ovf_d = ovf_n;
        bad_d = bad_n;
        neg_d = neg_n;
        cnt_d = cnt_n;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      bad_q       <= 1'b0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      bad_q       <= bad_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    error_q <= error_d;
  end

  assign parsed_value_o = value_q;
  assign parse_error_o  = error_q;
  assign out_valid_o    = out_valid_q;

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && error_q) |-> (value_q == 64'd0))
    else $error("error result with non-zero value");
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt + 1'b1)
    else $error("digit count beyond saturation");
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("final item left no result");
`endif

endmodule
